// ===== rtl/assert_macros.svh =====
// Assertion macros for the block that checks its own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property sampled on the rising clock edge, switched off during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// An implication sampled on the rising clock edge, switched off during reset.
`define ASSERT_IMPL(label, pre, post, msg) \
  `ASSERT_CLK(label, (pre) |-> (post), msg)

`endif

// ===== rtl/rdof_pkg.sv =====
package rdof_pkg;

  // Codes of the action field of an input item.
  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  // Width of the access interval register and of the tick counter.
  localparam int unsigned IntervalBits = 16;

endpackage

// ===== rtl/rate_divided_overwrite_fifo.sv =====
// First-in first-out buffer of DEPTH words that stores at a divided rate.
// Input channel (in_valid_i / in_stall_o) carries one item per handshake:
// a tick (action 0) advances the tick counter and, on every
// access_interval-th tick, stores source_word_i as the newest entry; a
// read (action 1) pops the oldest entry, if any. A store into a full buffer
// overwrites the oldest entry and flags it as dropped.
// Output channel (out_valid_o / out_stall_i) returns exactly one result
// item for every input item, in order. The result appears in the cycle after
// the input item is accepted: the entry store is a synchronous memory whose
// registered read port delivers the popped word together with the result.
// An item is taken in every cycle while the receiver does not stall; a
// stalled result holds the single output register and stalls the input.
// The user must write the access interval via cfg_we_i / cfg_wdata_i only
// while idle; the block does not enforce it. Reset empties the buffer, sets
// the tick counter and the interval to one and clears the output register;
// the memory is not cleared since only written entries are ever popped.
`include "assert_macros.svh"

module rate_divided_overwrite_fifo #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // Configuration write.
  input  logic                                      cfg_we_i,
  input  logic [rdof_pkg::IntervalBits-1:0]         cfg_wdata_i,
  // Input channel.
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic                                      action_i,
  input  logic signed [WORD_BITS-1:0]               source_word_i,
  // Output channel.
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic                                      read_valid_o,
  output logic signed [WORD_BITS-1:0]               read_word_o,
  output logic                                      source_taken_o,
  output logic                                      dropped_oldest_o,
  output logic [$clog2(DEPTH+1)-1:0]                fill_level_o
);

  localparam int unsigned AddrBits  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountBits = $clog2(DEPTH + 1);
  localparam int unsigned IB        = rdof_pkg::IntervalBits;

  localparam logic [AddrBits-1:0]  LastAddr  = AddrBits'(DEPTH - 1);
  localparam logic [CountBits-1:0] FullCount = CountBits'(DEPTH);
  localparam logic [AddrBits:0]    DepthWide = (AddrBits + 1)'(DEPTH);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  logic [AddrBits-1:0]  oldest_q, oldest_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [IB-1:0]        tick_q, tick_d;
  logic [IB-1:0]        interval_q;

  logic out_valid_q, read_valid_q, taken_q, dropped_q;
  logic read_valid_d, taken_d, dropped_d;

  logic                 in_acc;
  logic                 is_read;
  logic                 pop;
  logic                 store;
  logic                 full;
  logic [AddrBits-1:0]  oldest_inc;
  logic [AddrBits:0]    slot_sum;
  logic [AddrBits-1:0]  slot;
  logic [AddrBits-1:0]  wr_addr;

  // Handshake: the single output register parts the two channels.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_read    = (action_i == rdof_pkg::ACT_READ);

  // Pointer arithmetic modulo DEPTH.
  assign full       = (count_q == FullCount);
  assign oldest_inc = (oldest_q == LastAddr) ? '0 : oldest_q + 1'b1;
  assign slot_sum   = {1'b0, oldest_q} + (AddrBits + 1)'(count_q);
  assign slot       = (slot_sum >= DepthWide) ? AddrBits'(slot_sum - DepthWide)
                                              : slot_sum[AddrBits-1:0];
  assign wr_addr    = full ? oldest_q : slot;

  // Decode of the accepted item and the next control state.
  always_comb begin
    pop          = 1'b0;
    store        = 1'b0;
    oldest_d     = oldest_q;
    count_d      = count_q;
    tick_d       = tick_q;
    read_valid_d = 1'b0;
    taken_d      = 1'b0;
    dropped_d    = 1'b0;
    if (in_acc) begin
      if (is_read) begin
        if (count_q != '0) begin
          pop          = 1'b1;
          read_valid_d = 1'b1;
          oldest_d     = oldest_inc;
          count_d      = count_q - 1'b1;
        end
      end else if (tick_q != interval_q) begin
        tick_d = tick_q + 1'b1;
      end else begin
        store   = 1'b1;
        taken_d = 1'b1;
        tick_d  = IB'(1);
        if (full) begin
          dropped_d = 1'b1;
          oldest_d  = oldest_inc;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  // Entry store: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (store) begin
      mem_q[wr_addr] <= source_word_i;
    end
    if (pop) begin
      rdata_q <= mem_q[oldest_q];
    end
  end

  // Control state, interval register and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q     <= '0;
      count_q      <= '0;
      tick_q       <= IB'(1);
      interval_q   <= IB'(1);
      out_valid_q  <= 1'b0;
      read_valid_q <= 1'b0;
      taken_q      <= 1'b0;
      dropped_q    <= 1'b0;
    end else begin
      oldest_q <= oldest_d;
      count_q  <= count_d;
      tick_q   <= tick_d;
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        out_valid_q  <= 1'b1;
        read_valid_q <= read_valid_d;
        taken_q      <= taken_d;
        dropped_q    <= dropped_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result fields; the fill level only moves when an item is accepted.
  assign out_valid_o      = out_valid_q;
  assign read_valid_o     = read_valid_q;
  assign read_word_o      = read_valid_q ? rdata_q : '0;
  assign source_taken_o   = taken_q;
  assign dropped_oldest_o = dropped_q;
  assign fill_level_o     = count_q;

  // Checks on the buffer bookkeeping.
  `ASSERT_CLK(a_count_bound, count_q <= FullCount, "fill count above depth")
  `ASSERT_IMPL(a_drop_full, out_valid_q && dropped_q, taken_q && full,
               "dropped entry without a full buffer")
  `ASSERT_IMPL(a_read_excl, out_valid_q && read_valid_q, !taken_q && !dropped_q,
               "read result also flags a store")
  `ASSERT_IMPL(a_pop_count, pop, ##1 (count_q == $past(count_q) - 1'b1),
               "pop did not lower the fill count")

endmodule
